// File: design/sem_pkg.sv
// Shared types and constants for the Sobel edge magnitude block.
package sem_pkg;

  localparam int unsigned PixW   = 24;
  localparam int unsigned ColW   = 12;
  localparam int unsigned RowW   = 13;
  localparam int unsigned CntW   = 23;
  localparam int unsigned SumW   = 17;
  localparam int unsigned MaxHeight = 4096;
  localparam logic [SumW-1:0] SatLimit = 17'd65280;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_e;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture the input item
    logic shift;     // shift window, write line stores
    logic compute;   // latch gradients / start root
    logic root_step; // one square-root step
    logic finish;    // load output register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic drop;      // flush while pixels are still due
    logic emit;      // item produces a result
    logic root_done;
  } dp_sts_t;

  // gradient sum of squares for one channel
  function automatic logic [SumW-1:0] sq_sum(input logic signed [11:0] gx,
                                            input logic signed [11:0] gy);
    logic [10:0] ax;
    logic [10:0] ay;
    logic [21:0] s;
    ax = gx[11] ? 11'(-gx) : gx[10:0];
    ay = gy[11] ? 11'(-gy) : gy[10:0];
    s  = 22'(ax * ax) + 22'(ay * ay);
    return (s > 22'(SatLimit)) ? SumW'(SatLimit) + SumW'(1) : s[SumW-1:0];
  endfunction

endpackage

// File: design/sem_ram.sv
// Generic single-port RAM with registered read.
module sem_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end
  assign rdata_o = rdata_q;
endmodule

// File: design/sem_ctrl.sv
// Sequencer: load, line-store read, window update, gradient, root iterations, output.
module sem_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            out_free_i,
  output sem_pkg::dp_cmd_t cmd_o,
  input  sem_pkg::dp_sts_t sts_i
);
  import sem_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_SHIFT, S_GRAD, S_ROOT, S_OUT
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_READ;
        end
      end
      S_READ: begin
        state_d = sts_i.drop ? S_IDLE : S_SHIFT;
      end
      S_SHIFT: begin
        cmd_o.shift = 1'b1;
        state_d     = sts_i.emit ? S_GRAD : S_IDLE;
      end
      S_GRAD: begin
        cmd_o.compute = 1'b1;
        state_d       = S_ROOT;
      end
      S_ROOT: begin
        if (sts_i.root_done) begin
          state_d = S_OUT;
        end else begin
          cmd_o.root_step = 1'b1;
        end
      end
      S_OUT: begin
        if (out_free_i) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> out_free_i) else $error("output overwritten");
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o)) else $error("multiple commands");
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> !in_ready_o) else $error("ready while busy");
endmodule

// File: design/sem_dp.sv
// Datapath: position counters, line stores, 3x3 window, gradients, iterative roots.
module sem_dp #(
  parameter int unsigned MaxWidth = 2048
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  sem_pkg::dp_cmd_t         cmd_i,
  output sem_pkg::dp_sts_t         sts_o,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_index_i,
  input  logic [15:0]              cfg_data_i,
  input  logic [7:0]               blue_in_i,
  input  logic [7:0]               green_in_i,
  input  logic [7:0]               red_in_i,
  input  logic                     flush_i,
  output logic                     res_valid_o,
  input  logic                     res_ready_i,
  output logic                     out_free_o,
  output logic [7:0]               blue_out_o,
  output logic [7:0]               green_out_o,
  output logic [7:0]               red_out_o,
  output logic                     frame_end_o
);
  import sem_pkg::*;

  localparam int unsigned AddrW = $clog2(MaxWidth);
  localparam int unsigned WCapW = $clog2(MaxWidth + 1);

  logic [ColW-1:0] width_q;
  logic [RowW-1:0] height_q;
  logic [AddrW:0]  col_q;
  logic [RowW-1:0] row_q;
  logic [CntW-1:0] cnt_q;
  logic [PixW-1:0] pix_q;
  logic            flush_q;
  logic [PixW-1:0] win_q [3][3];
  logic            left_ok_q, right_ok_q;
  logic [SumW-1:0] s_q [3];
  logic [SumW-1:0] rem_q [3];
  logic [SumW-1:0] root_q [3];
  logic [SumW-1:0] bit_q;
  logic            res_valid_q;
  logic [7:0]      res_q [3];
  logic            last_q;

  // effective sizes
  logic [WCapW:0]  w_eff;
  logic [RowW:0]   h_eff;
  always_comb begin
    if (width_q == '0) w_eff = (WCapW+1)'(1);
    else if ({2'b0, width_q} > 14'(MaxWidth)) w_eff = (WCapW+1)'(MaxWidth);
    else w_eff = (WCapW+1)'(width_q);
    if (height_q == '0) h_eff = (RowW+1)'(1);
    else if (height_q > RowW'(MaxHeight)) h_eff = (RowW+1)'(MaxHeight);
    else h_eff = (RowW+1)'(height_q);
  end

  logic [AddrW-1:0] ic;
  logic             in_frame;
  assign ic       = (col_q < (AddrW+1)'(MaxWidth)) ? col_q[AddrW-1:0] : '0;
  assign in_frame = {1'b0, row_q} < h_eff;

  assign sts_o.drop = in_frame && flush_q;
  assign sts_o.emit = (row_q >= RowW'(2)) || (row_q == RowW'(1) && ic != '0);
  assign sts_o.root_done = (bit_q == '0);

  // line stores, read in S_READ, written in S_SHIFT
  logic [PixW-1:0] top_rd, mid_rd, v;
  assign v = in_frame ? pix_q : '0;
  sem_ram #(.Width(PixW), .Depth(MaxWidth)) u_upper (
    .clk_i, .we_i(cmd_i.shift), .re_i(~cmd_i.shift),
    .addr_i(ic), .wdata_i(mid_rd), .rdata_o(top_rd));
  sem_ram #(.Width(PixW), .Depth(MaxWidth)) u_middle (
    .clk_i, .we_i(cmd_i.shift), .re_i(~cmd_i.shift),
    .addr_i(ic), .wdata_i(v), .rdata_o(mid_rd));

  logic top_ok, mid_ok;
  assign top_ok = (row_q >= RowW'(2)) && ({1'b0, row_q} - (RowW+1)'(2) < h_eff);
  assign mid_ok = (row_q >= RowW'(1)) && ({1'b0, row_q} - (RowW+1)'(1) < h_eff);

  logic [WCapW:0] cc;
  assign cc = (ic == '0) ? w_eff - (WCapW+1)'(1) : (WCapW+1)'(ic) - (WCapW+1)'(1);

  // gradients
  logic signed [11:0] gx [3];
  logic signed [11:0] gy [3];
  always_comb begin
    logic signed [11:0] p [3][3];
    for (int ch = 0; ch < 3; ch++) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          p[r][c] = {4'b0, win_q[r][c][8*ch +: 8]};
        end
        if (!left_ok_q) p[r][0] = '0;
        if (!right_ok_q) p[r][2] = '0;
      end
      gx[ch] = (p[0][2] - p[0][0]) + ((p[1][2] - p[1][0]) <<< 1) + (p[2][2] - p[2][0]);
      gy[ch] = (p[2][0] + (p[2][1] <<< 1) + p[2][2]) - (p[0][0] + (p[0][1] <<< 1) + p[0][2]);
    end
  end

  logic [CntW+1:0] area;
  assign area = (CntW+2)'(w_eff) * (CntW+2)'(h_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= ColW'(2048);
      height_q    <= RowW'(1);
      col_q       <= '0;
      row_q       <= '0;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
      last_q      <= 1'b0;
      bit_q       <= '0;
      left_ok_q   <= 1'b0;
      right_ok_q  <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= '0;
        end
      end
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == REG_WIDTH) width_q <= cfg_data_i[ColW-1:0];
        else height_q <= cfg_data_i[RowW-1:0];
      end
      if (res_valid_q && res_ready_i) res_valid_q <= 1'b0;
      if (cmd_i.shift) begin
        for (int r = 0; r < 3; r++) begin
          win_q[r][0] <= win_q[r][1];
          win_q[r][1] <= win_q[r][2];
        end
        win_q[0][2] <= top_ok ? top_rd : '0;
        win_q[1][2] <= mid_ok ? mid_rd : '0;
        win_q[2][2] <= v;
        left_ok_q   <= cc >= (WCapW+1)'(1);
        right_ok_q  <= cc + (WCapW+1)'(1) < w_eff;
        if ((WCapW+1)'(ic) + (WCapW+1)'(1) >= w_eff) begin
          col_q <= '0;
          row_q <= row_q + RowW'(1);
        end else begin
          col_q <= (AddrW+1)'(ic) + (AddrW+1)'(1);
        end
      end
      if (cmd_i.compute) begin
        bit_q <= SumW'(1) << 16;
      end else if (cmd_i.root_step) begin
        bit_q <= bit_q >> 2;
      end
      if (cmd_i.finish) begin
        res_valid_q <= 1'b1;
        if ((CntW+2)'(cnt_q) + (CntW+2)'(1) >= area) begin
          last_q <= 1'b1;
          cnt_q  <= '0;
          col_q  <= '0;
          row_q  <= '0;
          for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
              win_q[r][c] <= '0;
            end
          end
        end else begin
          last_q <= 1'b0;
          cnt_q  <= cnt_q + CntW'(1);
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pix_q   <= {red_in_i, green_in_i, blue_in_i};
      flush_q <= flush_i;
    end
    for (int ch = 0; ch < 3; ch++) begin
      if (cmd_i.compute) begin
        s_q[ch]    <= sq_sum(gx[ch], gy[ch]);
        rem_q[ch]  <= sq_sum(gx[ch], gy[ch]);
        root_q[ch] <= '0;
      end else if (cmd_i.root_step) begin
        // root is scaled by the current bit pair until the last step
        if (rem_q[ch] >= root_q[ch] + bit_q) begin
          rem_q[ch]  <= rem_q[ch] - (root_q[ch] + bit_q);
          root_q[ch] <= (root_q[ch] >> 1) + bit_q;
        end else begin
          root_q[ch] <= root_q[ch] >> 1;
        end
      end
      if (cmd_i.finish) begin
        // rounding: remainder above root means s > n*n + n
        if (s_q[ch] > SatLimit) res_q[ch] <= 8'd255;
        else if (rem_q[ch] > root_q[ch]) res_q[ch] <= 8'(root_q[ch] + SumW'(1));
        else res_q[ch] <= root_q[ch][7:0];
      end
    end
  end

  assign out_free_o  = !res_valid_q || res_ready_i;
  assign res_valid_o = res_valid_q;
  assign blue_out_o  = res_q[0];
  assign green_out_o = res_q[1];
  assign red_out_o   = res_q[2];
  assign frame_end_o = last_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_ready_i |=> res_valid_q) else $error("result lost");
  a_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= (AddrW+1)'(MaxWidth)) else $error("column out of range");
  a_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.root_step |-> bit_q != '0) else $error("root step past end");
endmodule

// File: design/sobel_edge_magnitude_rgb.sv
// Top level: Sobel edge magnitude over an RGB raster stream.
//  channel | signals                                      | direction
//  input   | in_valid_i/in_ready_o, blue/green/red_in_i, flush_i | in
//  output  | out_valid_o/out_ready_i, blue/green/red_out_o, frame_end_o | out
//  config  | cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i | in
// An item with no result passes through accept, line-store read and window shift;
// a flush dropped while pixels are due ends after the read. An item with a result runs
// accept, read, shift, gradient, 9 root steps run on all three channels at once,
// a check that sees the root finish, and the output load.
// The output load waits while the previous result is not taken; the output
// register lets the next item start while a result waits.
// Reset: async active low; no memory clearing pass, stores are read only
// after being written.
module sobel_edge_magnitude_rgb #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [0:0] cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] blue_in_i,
  input  logic [7:0] green_in_i,
  input  logic [7:0] red_in_i,
  input  logic       flush_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] blue_out_o,
  output logic [7:0] green_out_o,
  output logic [7:0] red_out_o,
  output logic       frame_end_o
);
  import sem_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    out_free;

  assign cfg_ready_o = 1'b1;

  sem_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .out_free_i(out_free), .cmd_o(cmd), .sts_i(sts));

  sem_dp #(.MaxWidth(MAX_WIDTH)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .cfg_valid_i, .cfg_index_i(cfg_index_i[0]), .cfg_data_i,
    .blue_in_i, .green_in_i, .red_in_i, .flush_i,
    .res_valid_o(out_valid_o), .res_ready_i(out_ready_i), .out_free_o(out_free),
    .blue_out_o, .green_out_o, .red_out_o, .frame_end_o);
endmodule

// File: sim/sem_checker.sv
// Checker for the Sobel edge block: predicts results from accepted items and compares.
module sem_checker #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  blue_in_i,
  input  logic [7:0]  green_in_i,
  input  logic [7:0]  red_in_i,
  input  logic        flush_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  blue_out_i,
  input  logic [7:0]  green_out_i,
  input  logic [7:0]  red_out_i,
  input  logic        frame_end_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          edge_count_o,
  output int          frame_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import sem_pkg::*;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       frame_end;
  } edge_px_t;

  logic [11:0] width_q;
  logic [12:0] height_q;
  logic [23:0] upper_mem [MAX_WIDTH];
  logic [23:0] middle_mem [MAX_WIDTH];
  logic [23:0] win [3][3];
  int unsigned col_q, row_q, out_cnt_q;
  edge_px_t edge_q[$];

  assign pending_o = edge_q.size();

  function automatic logic [7:0] grad_mag(int gx, int gy);
    int unsigned s, n;
    s = gx * gx + gy * gy;
    if (s > 65280) return 8'd255;
    n = 0;
    while ((n + 1) * (n + 1) <= s) n++;
    if (s > n * n + n) n++;
    return (n > 255) ? 8'd255 : 8'(n);
  endfunction

  task automatic clear_frame();
    for (int r = 0; r < 3; r++) for (int c = 0; c < 3; c++) win[r][c] = '0;
    col_q = 0;
    row_q = 0;
    out_cnt_q = 0;
  endtask

  // Advance the predicted pipeline by one accepted item.
  task automatic sobel_predict(logic [23:0] px, logic flush);
    int unsigned w, h, ir, ic, cc;
    logic [23:0] v, top, mid;
    logic emit, left_ok, right_ok;
    int gx, gy, p;
    edge_px_t e;
    w = (width_q == 0) ? 1 : ((width_q > MAX_WIDTH) ? MAX_WIDTH : width_q);
    h = (height_q == 0) ? 1 : ((height_q > MaxHeight) ? MaxHeight : height_q);
    ir = row_q;
    ic = (col_q < MAX_WIDTH) ? col_q : 0;
    if (ir < h && flush) return;
    v = (ir < h) ? px : '0;
    top = upper_mem[ic];
    mid = middle_mem[ic];
    upper_mem[ic] = mid;
    middle_mem[ic] = v;
    if (!(ir >= 2 && ir - 2 < h)) top = '0;
    if (!(ir >= 1 && ir - 1 < h)) mid = '0;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = v;
    emit = ir >= 2 || (ir == 1 && ic >= 1);
    cc = (ic == 0) ? w - 1 : ic - 1;
    if (ic + 1 >= w) begin
      col_q = 0;
      row_q = (ir + 1) & 32'h1FFF;
    end else begin
      col_q = ic + 1;
    end
    if (!emit) return;
    left_ok = cc >= 1;
    right_ok = cc + 1 < w;
    for (int ch = 0; ch < 3; ch++) begin
      gx = 0;
      gy = 0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          if ((c == 0 && !left_ok) || (c == 2 && !right_ok)) continue;
          p = (win[r][c] >> (8 * ch)) & 8'hFF;
          gx += p * (c - 1) * ((r == 1) ? 2 : 1);
          gy += p * (r - 1) * ((c == 1) ? 2 : 1);
        end
      end
      case (ch)
        0: e.blue = grad_mag(gx, gy);
        1: e.green = grad_mag(gx, gy);
        default: e.red = grad_mag(gx, gy);
      endcase
    end
    e.frame_end = (out_cnt_q + 1 >= w * h);
    if (e.frame_end) clear_frame();
    else out_cnt_q = (out_cnt_q + 1) & 32'h7FFFFF;
    edge_q.push_back(e);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    edge_px_t got, want;
    if (!rst_ni) begin
      width_q = 12'd2048;
      height_q = 13'd1;
      clear_frame();
      edge_q.delete();
      fail_count_o = 0;
      edge_count_o = 0;
      frame_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_WIDTH) width_q = cfg_data_i[11:0];
        else height_q = cfg_data_i[12:0];
      end
      if (out_valid_i && out_ready_i) begin
        got = '{blue_out_i, green_out_i, red_out_i, frame_end_i};
        edge_count_o++;
        if (frame_end_i) frame_count_o++;
        if (edge_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("unexpected result %p", got);
        end else begin
          want = edge_q.pop_front();
          if (got !== want) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("mismatch: expected %p, got %p", want, got);
          end
        end
      end
      if (in_valid_i && in_ready_i)
        sobel_predict({red_in_i, green_in_i, blue_in_i}, flush_i);
    end
  end
endmodule

// File: sim/tb.sv
// Testbench top: stimulus, configuration phases and verdict for the Sobel edge block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sem_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [0:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [7:0] blue_in_i = '0, green_in_i = '0, red_in_i = '0;
  logic flush_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [7:0] blue_out_o, green_out_o, red_out_o;
  logic frame_end_o;
  int fail_count, pending, edge_count, frame_count;
  int pixel_count;
  int item_count;
  bit quiet;

  always #5 clk_i = ~clk_i;

  sobel_edge_magnitude_rgb DUT (.*);

  sem_checker u_checker (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .blue_in_i, .green_in_i, .red_in_i, .flush_i,
    .out_valid_i(out_valid_o), .out_ready_i, .blue_out_i(blue_out_o),
    .green_out_i(green_out_o), .red_out_i(red_out_o), .frame_end_i(frame_end_o),
    .fail_count_o(fail_count), .pending_o(pending), .edge_count_o(edge_count),
    .frame_count_o(frame_count)
  );

  always @(posedge clk_i) begin
    out_ready_i <= quiet || ($urandom_range(99) >= 11);
  end

  // valid stays high after the transfer; the caller drops it
  task automatic write_reg(reg_idx_e idx, logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // valid stays high after the transfer unless a gap follows; the caller drops it
  task automatic send_item(logic [23:0] px, logic flush);
    if (!quiet && $urandom_range(99) < 11) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while (!quiet && $urandom_range(99) < 11);
    end
    in_valid_i <= 1'b1;
    {red_in_i, green_in_i, blue_in_i} <= px;
    flush_i <= flush;
    do @(posedge clk_i); while (!in_ready_o);
    item_count++;
    if (!flush) pixel_count++;
  endtask

  // mode: 0 random, 1 all zero, 2 all max, 3 checkerboard
  task automatic run_frame(int w, int h, int mode, bit noise);
    logic [23:0] px;
    write_reg(REG_WIDTH, 16'(w));
    write_reg(REG_HEIGHT, 16'(h));
    cfg_valid_i <= 1'b0;
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        case (mode)
          1: px = '0;
          2: px = '1;
          3: px = ((r + c) % 2) ? '1 : '0;
          default: px = $urandom();
        endcase
        // a flush while pixels are due is ignored
        if (noise && $urandom_range(9) == 0) send_item($urandom(), 1'b1);
        send_item(px, 1'b0);
      end
    end
    // pixel data during draining is dropped
    for (int i = 0; i <= w; i++) send_item($urandom(), noise ? 1'($urandom()) : 1'b1);
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  initial begin
    #2ms;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    quiet = 1'b0;
    // directed frames: extremes of size and of pixel values
    run_frame(1, 1, 0, 0);
    run_frame(3, 3, 2, 0);
    run_frame(4, 3, 3, 0);
    run_frame(2, 2, 1, 1);
    run_frame(5, 1, 2, 0);
    run_frame(1, 5, 0, 1);
    run_frame(256, 2, 0, 0);
    run_frame(1, 300, 0, 0);
    run_frame(0, 0, 0, 0);
    quiet = 1'b1;
    run_frame(8, 6, 0, 1);
    quiet = 1'b0;
    while (item_count < 1850) begin
      run_frame($urandom_range(1, 12), $urandom_range(1, 10), $urandom_range(3), 1);
    end
    $display("%0d items (%0d pixels) over %0d frames, %0d edge results checked",
             item_count, pixel_count, frame_count, edge_count);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
